FILE: src/nfce_pkg.sv
// nfce_pkg: shared types, symbol codes and patterns for the NFC-A card frame encoder.
// No dependencies; imported by every nfce module.
package nfce_pkg;

	localparam int MAX_SYMS  = 14;
	localparam int SYM_W     = 2;
	localparam int CNT_W     = 4;
	localparam int PAT_W     = 16;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [SYM_W-1:0] {
		SYM_D = 2'd0,
		SYM_E = 2'd1,
		SYM_F = 2'd2
	} sym_t;

	localparam logic [PAT_W-1:0] PAT_D = 16'h0055;
	localparam logic [PAT_W-1:0] PAT_E = 16'h5500;
	localparam logic [PAT_W-1:0] PAT_F = 16'h0000;

	localparam logic [CNT_W-1:0] FULL_BITS = 4'd8;

	// one queued element: symbol list, first symbol in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]            count;
		logic [MAX_SYMS*SYM_W-1:0]   syms;
	} desc_t;

	localparam int DESC_W = CNT_W + MAX_SYMS*SYM_W;

	function automatic logic [PAT_W-1:0] sym_pattern(input logic [SYM_W-1:0] code);
		logic [PAT_W-1:0] pat;
		case (code)
			SYM_D:   pat = PAT_D;
			SYM_E:   pat = PAT_E;
			default: pat = PAT_F;
		endcase
		return pat;
	endfunction

endpackage

FILE: src/nfce_front.sv
// nfce_front: takes one input item apart into its ordered symbol list and length.
// Depends on nfce_pkg.
module nfce_front (
	input  logic [7:0]            data_byte,
	input  logic                  parity_bit,
	input  logic [3:0]            bit_count,
	input  logic                  frame_first,
	input  logic                  frame_last,
	output nfce_pkg::desc_t       desc,
	output logic                  nonempty
);
	import nfce_pkg::*;

	localparam int BODY_SYMS = 10;
	localparam int SOF_SYMS  = 4;

	logic [CNT_W-1:0]            n_data;
	logic [BODY_SYMS*SYM_W-1:0]  body;
	logic [SOF_SYMS*SYM_W-1:0]   sof;
	logic [MAX_SYMS*SYM_W-1:0]   syms;
	logic [CNT_W-1:0]            total;

	always_comb begin
		// counts above eight act as a full byte plus parity
		n_data = bit_count[3] ? (FULL_BITS + 4'd1) : bit_count;
		for (int k = 0; k < BODY_SYMS; k++) begin
			if (CNT_W'(k) >= n_data) begin
				body[k*SYM_W +: SYM_W] = SYM_F;
			end else if (k < 8) begin
				body[k*SYM_W +: SYM_W] = data_byte[k] ? SYM_D : SYM_E;
			end else begin
				body[k*SYM_W +: SYM_W] = parity_bit ? SYM_D : SYM_E;
			end
		end
		sof = {SYM_D, SYM_F, SYM_F, SYM_F};
		if (frame_first) begin
			syms = {body, sof};
		end else begin
			syms = {{SOF_SYMS*SYM_W{1'b0}}, body};
		end
		total = (frame_first ? 4'd4 : 4'd0) + n_data + {3'd0, frame_last};
		desc.count = total;
		desc.syms  = syms;
		nonempty   = (total != '0);
	end

endmodule

FILE: src/nfce_queue.sv
// nfce_queue: small FIFO of symbol-list descriptors between front and back.
// Depends on nfce_pkg.
module nfce_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nfce_pkg::desc_t  push_desc,
	output logic             full,
	input  logic             pop,
	output nfce_pkg::desc_t  pop_desc,
	output logic             not_empty
);
	import nfce_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	desc_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;

	assign full      = (fill_q == FILL_W'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("queue fill above depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("queue fill did not grow on push");
`endif

endmodule

FILE: src/nfce_back.sv
// nfce_back: drains descriptors one symbol per cycle into the output register while m_tready allows.
// Depends on nfce_pkg.
module nfce_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  nfce_pkg::desc_t  q_desc,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast
);
	import nfce_pkg::*;

	logic                        out_valid_q;
	logic [SYM_W-1:0]            code_q;
	logic                        last_q;
	logic [MAX_SYMS*SYM_W-1:0]   cur_q;
	logic [CNT_W-1:0]            rem_q;
	logic                        load_out;

	assign load_out = !out_valid_q || m_tready;
	assign q_pop    = load_out && (rem_q == '0) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			code_q      <= SYM_F;
			last_q      <= 1'b0;
			cur_q       <= '0;
			rem_q       <= '0;
		end else if (load_out) begin
			if (rem_q != '0) begin
				out_valid_q <= 1'b1;
				code_q      <= cur_q[SYM_W-1:0];
				last_q      <= (rem_q == 4'd1);
				cur_q       <= cur_q >> SYM_W;
				rem_q       <= rem_q - 1'b1;
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				code_q      <= q_desc.syms[SYM_W-1:0];
				last_q      <= (q_desc.count == 4'd1);
				cur_q       <= q_desc.syms >> SYM_W;
				rem_q       <= q_desc.count - 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'd0, sym_pattern(code_q), code_q};

`ifndef SYNTH
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < 4'(MAX_SYMS))
		else $error("remaining symbol count out of range");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (rem_q == '0))
		else $error("pop while element still draining");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (rem_q != '0))
		else $error("element ended without last symbol");
`endif

endmodule

FILE: src/nfc_a_card_frame_encoder_unit.sv
// nfc_a_card_frame_encoder_unit: NFC-A card-side transmit symbol encoder, top level.
// Depends on nfce_pkg, nfce_front, nfce_queue, nfce_back.
//
//   channel  dir  tdata (low bit up)                         tuser        tlast
//   s_*      in   data_byte[7:0] parity_bit bit_count[3:0]  frame_first  frame_last
//   m_*      out  symbol_code[1:0] phase_pattern[15:0]      -            last_symbol
//
// One symbol leaves per cycle while m_tready is high; an item has 0 to 14 symbols.
// Items are accepted every cycle while the descriptor queue has room (QUEUE_DEPTH entries).
// The output register drains the current descriptor, so sustained rate is set by symbol count.
// Items with no symbols are accepted and dropped without entering the queue.
// Reset clears the queue and the output register; m_tready low stalls the back end, and the input once the queue fills.
module nfc_a_card_frame_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // data_byte[7:0], parity_bit, bit_count[3:0], zero pad
	input  logic [0:0]   s_tuser,   // frame_first
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,   // symbol_code[1:0], phase_pattern[15:0], zero pad
	output logic         m_tlast
);
	import nfce_pkg::*;

	desc_t  front_desc;
	desc_t  q_desc;
	logic   nonempty;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready && nonempty;

	nfce_front u_front (
		.data_byte   (s_tdata[7:0]),
		.parity_bit  (s_tdata[8]),
		.bit_count   (s_tdata[12:9]),
		.frame_first (s_tuser[0]),
		.frame_last  (s_tlast),
		.desc        (front_desc),
		.nonempty    (nonempty)
	);

	nfce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (front_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_desc  (q_desc),
		.not_empty (q_valid)
	);

	nfce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_desc   (q_desc),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: tb/tb_nfc_a_card_frame_encoder_unit.sv
// tb_nfc_a_card_frame_encoder_unit: self-checking testbench for the NFC-A card frame encoder.
// Drives directed and random frame elements on the input stream and checks every symbol.
// Depends on nfce_pkg and nfc_a_card_frame_encoder_unit.
`timescale 1ns / 1ps

module tb_nfc_a_card_frame_encoder_unit;
	import nfce_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 50;

	typedef struct {
		sym_t             code;
		logic [PAT_W-1:0] pat;
		logic             last;
	} symbol_t;

	class symbol_scoreboard;
		symbol_t expected_syms[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return expected_syms.size();
		endfunction

		function logic [PAT_W-1:0] pattern_of(input sym_t code);
			case (code)
				SYM_D:   return PAT_D;
				SYM_E:   return PAT_E;
				default: return PAT_F;
			endcase
		endfunction

		// expand one accepted element into its symbol sequence
		function void note_item(input logic [7:0] data, input logic par,
				input logic [CNT_W-1:0] cnt, input logic first, input logic last);
			sym_t             seq[$];
			logic [CNT_W-1:0] nbits;
			symbol_t          s;
			nbits = (cnt > FULL_BITS) ? FULL_BITS : cnt;
			if (first) begin
				seq.push_back(SYM_F);
				seq.push_back(SYM_F);
				seq.push_back(SYM_F);
				seq.push_back(SYM_D);
			end
			for (int i = 0; i < nbits; i++)
				seq.push_back(data[i] ? SYM_D : SYM_E);
			if (nbits == FULL_BITS)
				seq.push_back(par ? SYM_D : SYM_E);
			if (last)
				seq.push_back(SYM_F);
			foreach (seq[i]) begin
				s.code = seq[i];
				s.pat  = pattern_of(seq[i]);
				s.last = (i == seq.size() - 1);
				expected_syms.push_back(s);
			end
		endfunction

		task check_symbol(input logic [SYM_W-1:0] code, input logic [PAT_W-1:0] pat,
				input logic last);
			symbol_t e;
			if (expected_syms.size() == 0) begin
				report($sformatf("unexpected symbol code %0d pattern %h", code, pat));
			end else begin
				e = expected_syms.pop_front();
				if (code !== e.code)
					report($sformatf("symbol_code %0d, want %0d", code, e.code));
				if (pat !== e.pat)
					report($sformatf("phase_pattern %h, want %h", pat, e.pat));
				if (last !== e.last)
					report($sformatf("last_symbol %b, want %b", last, e.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // data_byte[7:0], parity_bit, bit_count[3:0], zero pad
	logic [0:0]  s_tuser;   // frame_first
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // symbol_code[1:0], phase_pattern[15:0], zero pad
	logic        m_tlast;

	symbol_scoreboard sb;
	int src_idle;
	int snk_stall;
	int cycles;

	nfc_a_card_frame_encoder_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #6 clk = ~clk;

	initial m_tready = 1'b0;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tdata[7:0], s_tdata[8], s_tdata[12:9], s_tuser[0], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_symbol(m_tdata[1:0], m_tdata[17:2], m_tlast);
		end
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task send_item(input logic [7:0] data, input logic par, input logic [3:0] cnt,
			input logic first, input logic last);
		@(negedge clk);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tdata  = {3'b000, cnt, par, data};
		s_tuser  = first;
		s_tlast  = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// mostly well-formed frames with random content, some noise elements
	task run_random(input int n_items);
		int sent;
		int len;
		logic [3:0] tail_cnt;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 70) begin
				if ($urandom_range(3) == 0) begin
					send_item(8'($urandom), 1'($urandom_range(1)), 4'd7, 1'b1, 1'b1);
					sent++;
				end else begin
					len = $urandom_range(1, 6);
					tail_cnt = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 7)) : 4'd8;
					for (int k = 0; k < len; k++)
						send_item(8'($urandom), 1'($urandom_range(1)),
							(k == len - 1) ? tail_cnt : 4'd8, k == 0, k == len - 1);
					sent += len;
				end
			end else begin
				send_item(8'($urandom), 1'($urandom_range(1)), 4'($urandom_range(15)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;
		src_idle  = 7;
		snk_stall = 87;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// empty element and flag-only elements
		send_item(8'h00, 1'b0, 4'd0, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 4'd0, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 4'd0, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 4'd0, 1'b1, 1'b1);
		// full bytes at the extremes
		send_item(8'hFF, 1'b1, 4'd8, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 4'd8, 1'b1, 1'b0);
		send_item(8'hA5, 1'b1, 4'd8, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 4'd8, 1'b0, 1'b1);
		// counts above eight act as a full byte
		send_item(8'h3C, 1'b1, 4'd9, 1'b0, 1'b0);
		send_item(8'hC3, 1'b0, 4'd12, 1'b1, 1'b0);
		send_item(8'h81, 1'b1, 4'd15, 1'b0, 1'b1);
		// short frames, parity ignored
		send_item(8'h26, 1'b1, 4'd7, 1'b1, 1'b1);
		send_item(8'h52, 1'b0, 4'd7, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 4'd1, 1'b0, 1'b0);
		send_item(8'hFE, 1'b1, 4'd2, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 4'd3, 1'b0, 1'b1);
		send_item(8'h0F, 1'b0, 4'd4, 1'b1, 1'b0);
		send_item(8'hF5, 1'b1, 4'd5, 1'b0, 1'b0);
		send_item(8'hAA, 1'b0, 4'd6, 1'b0, 1'b1);

		run_random(62);
		src_idle  = 87;
		snk_stall = 7;
		run_random(62);
		src_idle  = 0;
		snk_stall = 0;
		run_random(62);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
